// File: rtl/rfwl_pkg.sv
package rfwl_pkg;

    localparam int UID_LO_W  = 64;
    localparam int UID_HI_W  = 16;
    localparam int UID_LEN_W = 4;
    localparam int REQ_W     = 3;
    localparam int STATUS_W  = 2;
    localparam int MOVE_W    = 2;
    localparam int ANGLE_W   = 8;
    localparam int DELAY_W   = 16;
    localparam int CAL_W     = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam int DEF_TABLE_ENTRIES = 16;
    localparam int MAX_UID_BYTES     = 10;

    // request codes
    localparam logic [REQ_W-1:0] REQ_ARRIVE = 3'd0;
    localparam logic [REQ_W-1:0] REQ_LEAVE  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_ENROLL = 3'd2;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd3;
    localparam logic [REQ_W-1:0] REQ_LOCK   = 3'd4;
    localparam logic [REQ_W-1:0] REQ_TICK   = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFND  = 2'd3;

    // servo commands
    localparam logic [MOVE_W-1:0] MV_NONE  = 2'd0;
    localparam logic [MOVE_W-1:0] MV_OPEN  = 2'd1;
    localparam logic [MOVE_W-1:0] MV_CLOSE = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_DELAY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSED_OFS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OPENED_OFS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_CAL    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_CAL    = 3'd4;

    localparam logic [DELAY_W-1:0] RST_CLOSE_DELAY = 16'd1000;
    localparam logic [CAL_W-1:0]   RST_FULL_CAL    = 8'd180;
    localparam logic [ANGLE_W-1:0] ANGLE_MAX       = 8'd180;
    localparam int                 HALF_TURN       = 90;

    typedef struct packed {
        logic [UID_LEN_W-1:0] len;
        logic [UID_HI_W-1:0]  hi;
        logic [UID_LO_W-1:0]  lo;
    } t_entry;

    localparam t_entry PRESET_ENTRY = '{
        len: 4'd4,
        hi:  16'h0000,
        lo:  64'h0000_0000_F728_59E3
    };

endpackage

// File: rtl/rfwl_req_if.sv
interface rfwl_req_if
    import rfwl_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [REQ_W-1:0]     req_type;
    logic [UID_LO_W-1:0]  uid_low;
    logic [UID_HI_W-1:0]  uid_high;
    logic [UID_LEN_W-1:0] uid_bytes;

    modport source (output valid, req_type, uid_low, uid_high, uid_bytes, input ready);
    modport sink   (input valid, req_type, uid_low, uid_high, uid_bytes, output ready);
endinterface

// File: rtl/rfwl_rsp_if.sv
interface rfwl_rsp_if
    import rfwl_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [MOVE_W-1:0]   servo_move;
    logic [ANGLE_W-1:0]  servo_angle;
    logic                card_valid;
    logic                locked_now;
    logic                card_present_now;

    modport source (output valid, status, servo_move, servo_angle, card_valid, locked_now,
                    card_present_now, input ready);
    modport sink   (input valid, status, servo_move, servo_angle, card_valid, locked_now,
                    card_present_now, output ready);
endinterface

// File: rtl/rfid_whitelist_lock_controller_core.sv
// lock, tick, card-removed, refused enroll and unknown requests go from accept straight to
// the finishing state; card-arrived, enroll and remove requests first walk the table
// throughput: one request at a time, one entry read per cycle during a walk; a result left
// in the output register holds the next request back in the finishing state
// reset (synchronous, active low): flags, countdown and entry valid bits cleared, registers to
// defaults, entry 0 valid and reading as the preset identifier until overwritten
module rfid_whitelist_lock_controller_core
    import rfwl_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rfwl_req_if.sink              i_req,
    rfwl_rsp_if.source            o_rsp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // table index width and a walk counter that can hold the entry count itself
    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CW-1:0] CNT_END = CW'(TABLE_ENTRIES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN
    } t_state;

    t_state r_state;

    // configuration registers
    logic [DELAY_W-1:0] r_close_delay;
    logic [CAL_W-1:0]   r_closed_ofs;
    logic [CAL_W-1:0]   r_opened_ofs;
    logic [CAL_W-1:0]   r_zero_cal;
    logic [CAL_W-1:0]   r_full_cal;

    // controller state
    t_entry             r_held;
    logic               r_card_here;
    logic               r_valid_card;
    logic               r_lock;
    logic               r_pending;
    logic [DELAY_W-1:0] r_delay;

    // table: payload in memory, valid bits in flops
    t_entry                   mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_vld;
    logic                     r_e0_written;

    // request being worked on
    logic [REQ_W-1:0] r_req;
    t_entry           r_key;
    logic             r_free;      // walk looks for a free slot instead of a match
    logic             r_hit;
    logic [IW-1:0]    r_hit_idx;

    // walk pipeline
    logic [CW-1:0] r_cnt;
    logic          r_rd_vld;
    logic [IW-1:0] r_rd_idx;
    logic          r_rd_pre;
    t_entry        r_rd_data;

    // output register
    logic                r_out_vld;
    logic [STATUS_W-1:0] r_status;
    logic [MOVE_W-1:0]   r_move;
    logic [ANGLE_W-1:0]  r_angle;
    logic                r_out_cvalid;
    logic                r_out_lock;
    logic                r_out_card;

    // ---------------------------------------------------------------
    // request key: clamp length, zero the bytes beyond it
    // ---------------------------------------------------------------
    logic [UID_LEN_W-1:0] in_len;
    t_entry               in_key;
    logic                 in_take;

    always_comb begin
        in_len = (i_req.uid_bytes > UID_LEN_W'(MAX_UID_BYTES)) ?
                 UID_LEN_W'(MAX_UID_BYTES) : i_req.uid_bytes;
        in_key.len = in_len;
        for (int k = 0; k < 8; k++) begin
            in_key.lo[8*k +: 8] = (UID_LEN_W'(k) < in_len) ? i_req.uid_low[8*k +: 8] : 8'h00;
        end
        for (int k = 0; k < 2; k++) begin
            in_key.hi[8*k +: 8] = (UID_LEN_W'(k + 8) < in_len) ?
                                  i_req.uid_high[8*k +: 8] : 8'h00;
        end
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign in_take     = i_req.valid && (r_state == S_IDLE);

    // walk needed for arrival lookup, identifier removal, and an enroll that may proceed
    logic in_walk;
    logic in_free;
    assign in_free = (i_req.req_type == REQ_ENROLL) && r_card_here && !r_valid_card;
    assign in_walk = (i_req.req_type == REQ_ARRIVE) || (i_req.req_type == REQ_REMOVE) || in_free;

    // ---------------------------------------------------------------
    // table walk: one read per cycle, compare on the registered data
    // ---------------------------------------------------------------
    t_entry rd_entry;
    logic   s_hit;
    logic   s_end;
    logic   rd_en;

    assign rd_entry = r_rd_pre ? PRESET_ENTRY : r_rd_data;
    assign s_hit = r_rd_vld && (r_free ? !r_vld[r_rd_idx] :
                                (r_vld[r_rd_idx] && (rd_entry == r_key)));
    assign s_end = !r_rd_vld && (r_cnt == CNT_END);
    assign rd_en = (r_state == S_SCAN) && !s_hit && (r_cnt != CNT_END);

    // ---------------------------------------------------------------
    // servo angles, saturated to 0..180
    // ---------------------------------------------------------------
    logic signed [CAL_W+2:0] open_raw;
    logic        [CAL_W:0]   closed_raw;
    logic [ANGLE_W-1:0]      open_ang;
    logic [ANGLE_W-1:0]      closed_ang;

    always_comb begin
        open_raw = $signed({3'b000, r_full_cal}) - $signed((CAL_W+3)'(HALF_TURN))
                 + $signed({3'b000, r_opened_ofs});
        if (open_raw < 0) begin
            open_ang = '0;
        end else if (open_raw > $signed({3'b000, ANGLE_MAX})) begin
            open_ang = ANGLE_MAX;
        end else begin
            open_ang = open_raw[ANGLE_W-1:0];
        end
        closed_raw = {1'b0, r_zero_cal} + {1'b0, r_closed_ofs};
        closed_ang = (closed_raw > {1'b0, ANGLE_MAX}) ? ANGLE_MAX : closed_raw[ANGLE_W-1:0];
    end

    // ---------------------------------------------------------------
    // result and state update of the finished request
    // ---------------------------------------------------------------
    logic [STATUS_W-1:0] n_status;
    logic [MOVE_W-1:0]   n_move;
    logic [ANGLE_W-1:0]  n_angle;
    logic                n_card_here;
    logic                n_valid_card;
    logic                n_lock;
    logic                n_pending;
    logic [DELAY_W-1:0]  n_delay;
    logic                n_held_ld;
    logic                n_tab_wr;
    logic                n_tab_clr;
    logic [DELAY_W-1:0]  tick_left;

    always_comb begin
        n_status     = ST_OK;
        n_move       = MV_NONE;
        n_angle      = '0;
        n_card_here  = r_card_here;
        n_valid_card = r_valid_card;
        n_lock       = r_lock;
        n_pending    = r_pending;
        n_delay      = r_delay;
        n_held_ld    = 1'b0;
        n_tab_wr     = 1'b0;
        n_tab_clr    = 1'b0;
        tick_left    = (r_delay != '0) ? r_delay - 1'b1 : '0;
        case (r_req)
            REQ_ARRIVE: begin
                n_card_here  = 1'b1;
                n_held_ld    = 1'b1;
                n_valid_card = r_hit;
                if (r_hit && !r_lock) begin
                    n_move  = MV_OPEN;
                    n_angle = open_ang;
                end
            end
            REQ_LEAVE: begin
                if (!r_card_here) begin
                    n_status = ST_INVALID;
                end else begin
                    n_card_here  = 1'b0;
                    n_valid_card = 1'b0;
                    if (!r_pending && !r_lock) begin
                        if (r_close_delay == '0) begin
                            n_move  = MV_CLOSE;
                            n_angle = closed_ang;
                        end else begin
                            n_pending = 1'b1;
                            n_delay   = r_close_delay;
                        end
                    end
                end
            end
            REQ_ENROLL: begin
                if (!r_free) begin
                    n_status = ST_INVALID;
                end else if (r_hit) begin
                    n_tab_wr = 1'b1;
                end else begin
                    n_status = ST_FULL;
                end
            end
            REQ_REMOVE: begin
                if (r_hit) begin
                    n_tab_clr = 1'b1;
                end else begin
                    n_status = ST_NOTFND;
                end
            end
            REQ_LOCK: begin
                if (r_lock) begin
                    n_lock = 1'b0;
                end else begin
                    n_lock  = 1'b1;
                    n_move  = MV_CLOSE;
                    n_angle = closed_ang;
                end
            end
            REQ_TICK: begin
                if (r_pending) begin
                    n_delay = tick_left;
                    if (tick_left == '0) begin
                        n_pending = 1'b0;
                        if (!r_card_here) begin
                            n_move  = MV_CLOSE;
                            n_angle = closed_ang;
                        end
                    end
                end
            end
            default: begin
                n_status = ST_INVALID;
            end
        endcase
    end

    logic commit;
    assign commit = (r_state == S_FIN) && (!r_out_vld || o_rsp.ready);

    // ---------------------------------------------------------------
    // table memory: one write port, one registered read port
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (commit && n_tab_wr) begin
            mem[r_hit_idx] <= r_held;
        end
        if (rd_en) begin
            r_rd_data <= mem[r_cnt[IW-1:0]];
        end
    end

    // ---------------------------------------------------------------
    // control, state and output register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_close_delay <= RST_CLOSE_DELAY;
            r_closed_ofs  <= '0;
            r_opened_ofs  <= '0;
            r_zero_cal    <= '0;
            r_full_cal    <= RST_FULL_CAL;
            r_held        <= '0;
            r_card_here   <= 1'b0;
            r_valid_card  <= 1'b0;
            r_lock        <= 1'b0;
            r_pending     <= 1'b0;
            r_delay       <= '0;
            r_vld         <= TABLE_ENTRIES'(1);
            r_e0_written  <= 1'b0;
            r_rd_vld      <= 1'b0;
            r_out_vld     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CLOSE_DELAY: r_close_delay <= i_cfg_data;
                    CFG_CLOSED_OFS:  r_closed_ofs  <= i_cfg_data[CAL_W-1:0];
                    CFG_OPENED_OFS:  r_opened_ofs  <= i_cfg_data[CAL_W-1:0];
                    CFG_ZERO_CAL:    r_zero_cal    <= i_cfg_data[CAL_W-1:0];
                    CFG_FULL_CAL:    r_full_cal    <= i_cfg_data[CAL_W-1:0];
                    default: begin
                    end
                endcase
            end

            // drained by the receiver unless a new result replaces it in this cycle
            if (o_rsp.ready && !commit) begin
                r_out_vld <= 1'b0;
            end

            r_rd_vld <= rd_en;
            if (rd_en) begin
                r_rd_idx <= r_cnt[IW-1:0];
                r_rd_pre <= (r_cnt == '0) && !r_e0_written;
                r_cnt    <= r_cnt + 1'b1;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_req   <= i_req.req_type;
                        r_key   <= in_key;
                        r_free  <= in_free;
                        r_hit   <= 1'b0;
                        r_cnt   <= '0;
                        r_state <= in_walk ? S_SCAN : S_FIN;
                    end
                end
                S_SCAN: begin
                    if (s_hit) begin
                        r_hit     <= 1'b1;
                        r_hit_idx <= r_rd_idx;
                        r_state   <= S_FIN;
                    end else if (s_end) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (commit) begin
                        r_out_vld    <= 1'b1;
                        r_status     <= n_status;
                        r_move       <= n_move;
                        r_angle      <= n_angle;
                        r_out_cvalid <= n_valid_card;
                        r_out_lock   <= n_lock;
                        r_out_card   <= n_card_here;
                        r_card_here  <= n_card_here;
                        r_valid_card <= n_valid_card;
                        r_lock       <= n_lock;
                        r_pending    <= n_pending;
                        r_delay      <= n_delay;
                        if (n_held_ld) begin
                            r_held <= r_key;
                        end
                        if (n_tab_wr) begin
                            r_vld[r_hit_idx] <= 1'b1;
                            if (r_hit_idx == '0) begin
                                r_e0_written <= 1'b1;
                            end
                        end
                        if (n_tab_clr) begin
                            r_vld[r_hit_idx] <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid            = r_out_vld;
    assign o_rsp.status           = r_status;
    assign o_rsp.servo_move       = r_move;
    assign o_rsp.servo_angle      = r_angle;
    assign o_rsp.card_valid       = r_out_cvalid;
    assign o_rsp.locked_now       = r_out_lock;
    assign o_rsp.card_present_now = r_out_card;

`ifndef NO_ASSERTIONS
    // a running countdown always belongs to a pending close
    a_delay_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_delay != '0) |-> r_pending)
        else $error("countdown running without pending close");

    // a valid card implies a card on the reader
    a_valid_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid_card |-> r_card_here)
        else $error("valid card flag without card present");

    // a new result only comes from the finishing state
    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) && commit |=> r_out_vld && (r_state == S_IDLE))
        else $error("committed request did not load the output register");

    // read data in the compare stage only while walking the table
    a_rd_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> $past(r_state == S_SCAN))
        else $error("table read outside a walk");
`endif

endmodule

// File: dv/rfid_whitelist_lock_controller_core_tb.sv
`timescale 1ns / 1ps

module rfid_whitelist_lock_controller_core_tb;
    import rfwl_pkg::*;

    localparam int ACL_SIZE      = DEF_TABLE_ENTRIES;
    localparam int POOL_SIZE     = 24;
    // settling wait that covers the worst case request, a full table walk
    localparam int SETTLE_CYCLES = DEF_TABLE_ENTRIES + 8;

    // request codes the block must reject
    localparam logic [REQ_W-1:0]     REQ_BAD_6  = 3'd6;
    localparam logic [REQ_W-1:0]     REQ_BAD_7  = 3'd7;
    // register index with nothing behind it
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 3'd7;

    typedef struct {
        logic [REQ_W-1:0]     kind;
        logic [UID_LO_W-1:0]  lo;
        logic [UID_HI_W-1:0]  hi;
        logic [UID_LEN_W-1:0] len;
    } t_door_req;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [MOVE_W-1:0]   move;
        logic [ANGLE_W-1:0]  angle;
        logic                card_ok;
        logic                locked;
        logic                present;
    } t_door_rsp;

    // clock, reset and config port
    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    rfwl_req_if req_if ();
    rfwl_rsp_if rsp_if ();

    rfid_whitelist_lock_controller_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_rsp      (rsp_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor state: whitelist, current card, lock and close countdown
    // ------------------------------------------------------------------
    logic [UID_LO_W-1:0]  acl_lo   [ACL_SIZE];
    logic [UID_HI_W-1:0]  acl_hi   [ACL_SIZE];
    logic [UID_LEN_W-1:0] acl_len  [ACL_SIZE];
    logic                 acl_used [ACL_SIZE];
    logic [UID_LO_W-1:0]  cur_lo;
    logic [UID_HI_W-1:0]  cur_hi;
    logic [UID_LEN_W-1:0] cur_len;
    logic                 cur_here;
    logic                 cur_ok;
    logic                 is_locked;
    logic                 close_armed;
    logic [DELAY_W-1:0]   close_left;

    // predictor copy of the registers
    logic [DELAY_W-1:0] cfg_delay;
    logic [CAL_W-1:0]   cfg_closed_ofs;
    logic [CAL_W-1:0]   cfg_opened_ofs;
    logic [CAL_W-1:0]   cfg_zero_cal;
    logic [CAL_W-1:0]   cfg_full_cal;

    // request ids used by the generator, entry 0 is the preset card
    logic [UID_LO_W-1:0]  pool_lo  [POOL_SIZE];
    logic [UID_HI_W-1:0]  pool_hi  [POOL_SIZE];
    logic [UID_LEN_W-1:0] pool_len [POOL_SIZE];

    t_door_req door_req_pending_q[$];
    t_door_rsp door_rsp_due_q[$];
    t_door_req offered_req;

    int  n_queued      = 0;
    int  n_taken       = 0;
    int  n_mismatch    = 0;
    int  src_idle_pct  = 0;
    int  snk_stall_pct = 0;
    logic sink_hold    = 1'b0;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic logic [UID_LEN_W-1:0] uid_clamp(logic [UID_LEN_W-1:0] len);
        return (len > MAX_UID_BYTES) ? UID_LEN_W'(MAX_UID_BYTES) : len;
    endfunction

    function automatic logic [UID_LO_W-1:0] lo_mask(logic [UID_LEN_W-1:0] len);
        if (len >= 8) return '1;
        return (64'd1 << (8 * len)) - 64'd1;
    endfunction

    function automatic logic [UID_HI_W-1:0] hi_mask(logic [UID_LEN_W-1:0] len);
        if (len <= 8) return '0;
        if (len == 9) return 16'h00FF;
        return 16'hFFFF;
    endfunction

    function automatic logic [ANGLE_W-1:0] sat_deg(int a);
        if (a < 0) return '0;
        if (a > int'(ANGLE_MAX)) return ANGLE_MAX;
        return ANGLE_W'(a);
    endfunction

    function automatic logic [ANGLE_W-1:0] closed_deg();
        return sat_deg(int'(cfg_zero_cal) + int'(cfg_closed_ofs));
    endfunction

    // lowest valid entry holding this id, -1 if none
    function automatic int acl_find(logic [UID_LO_W-1:0] lo, logic [UID_HI_W-1:0] hi,
                                    logic [UID_LEN_W-1:0] len);
        for (int i = 0; i < ACL_SIZE; i++) begin
            if (acl_used[i] && acl_len[i] == len && acl_lo[i] == lo && acl_hi[i] == hi)
                return i;
        end
        return -1;
    endfunction

    // advance the predictor by one accepted request and return its response
    function automatic t_door_rsp predict_door_step(t_door_req r);
        t_door_rsp            o;
        logic [UID_LEN_W-1:0] len;
        logic [UID_LO_W-1:0]  lo;
        logic [UID_HI_W-1:0]  hi;
        int                   slot;
        len      = uid_clamp(r.len);
        lo       = r.lo & lo_mask(len);
        hi       = r.hi & hi_mask(len);
        o.status = ST_OK;
        o.move   = MV_NONE;
        o.angle  = '0;
        case (r.kind)
            REQ_ARRIVE: begin
                cur_here = 1'b1;
                cur_lo   = lo;
                cur_hi   = hi;
                cur_len  = len;
                // validity comes from this card alone
                cur_ok   = acl_find(lo, hi, len) >= 0;
                if (cur_ok && !is_locked) begin
                    o.move  = MV_OPEN;
                    o.angle = sat_deg(int'(cfg_full_cal) - HALF_TURN + int'(cfg_opened_ofs));
                end
            end
            REQ_LEAVE: begin
                if (!cur_here) begin
                    o.status = ST_INVALID;
                end else begin
                    cur_here = 1'b0;
                    cur_ok   = 1'b0;
                    // only one countdown at a time, none while locked
                    if (!close_armed && !is_locked) begin
                        if (cfg_delay == 0) begin
                            o.move  = MV_CLOSE;
                            o.angle = closed_deg();
                        end else begin
                            close_armed = 1'b1;
                            close_left  = cfg_delay;
                        end
                    end
                end
            end
            REQ_ENROLL: begin
                if (!cur_here || cur_ok) begin
                    o.status = ST_INVALID;
                end else begin
                    slot = -1;
                    for (int i = ACL_SIZE - 1; i >= 0; i--) begin
                        if (!acl_used[i]) slot = i;
                    end
                    if (slot < 0) begin
                        o.status = ST_FULL;
                    end else begin
                        acl_lo[slot]   = cur_lo;
                        acl_hi[slot]   = cur_hi;
                        acl_len[slot]  = cur_len;
                        acl_used[slot] = 1'b1;
                    end
                end
            end
            REQ_REMOVE: begin
                slot = acl_find(lo, hi, len);
                if (slot < 0) begin
                    o.status = ST_NOTFND;
                end else begin
                    acl_used[slot] = 1'b0;
                    acl_lo[slot]   = '0;
                    acl_hi[slot]   = '0;
                    acl_len[slot]  = '0;
                end
            end
            REQ_LOCK: begin
                if (is_locked) begin
                    is_locked = 1'b0;
                end else begin
                    o.move    = MV_CLOSE;
                    o.angle   = closed_deg();
                    is_locked = 1'b1;
                end
            end
            REQ_TICK: begin
                if (close_armed) begin
                    if (close_left > 0) close_left--;
                    if (close_left == 0) begin
                        close_armed = 1'b0;
                        // expiry closes even when locked, but not with a card on the reader
                        if (!cur_here) begin
                            o.move  = MV_CLOSE;
                            o.angle = closed_deg();
                        end
                    end
                end
            end
            default: o.status = ST_INVALID;
        endcase
        o.card_ok = cur_ok;
        o.locked  = is_locked;
        o.present = cur_here;
        return o;
    endfunction

    // ------------------------------------------------------------------
    // request generation
    // ------------------------------------------------------------------
    function automatic t_door_req mk_req(logic [REQ_W-1:0] kind, logic [UID_LO_W-1:0] lo,
                                         logic [UID_HI_W-1:0] hi, logic [UID_LEN_W-1:0] len);
        t_door_req r;
        r.kind = kind;
        r.lo   = lo;
        r.hi   = hi;
        r.len  = len;
        return r;
    endfunction

    // fully random payload
    function automatic t_door_req rand_card(logic [REQ_W-1:0] kind);
        return mk_req(kind, {$urandom, $urandom}, UID_HI_W'($urandom),
                      UID_LEN_W'($urandom_range(15, 0)));
    endfunction

    // known id with random garbage in the bytes past its length
    function automatic t_door_req pool_card(logic [REQ_W-1:0] kind, int idx);
        t_door_req            r;
        logic [UID_LEN_W-1:0] len;
        logic [UID_LO_W-1:0]  lm;
        logic [UID_HI_W-1:0]  hm;
        len    = pool_len[idx];
        lm     = lo_mask(len);
        hm     = hi_mask(len);
        r.kind = kind;
        r.lo   = (pool_lo[idx] & lm) | ({$urandom, $urandom} & ~lm);
        r.hi   = (pool_hi[idx] & hm) | (UID_HI_W'($urandom) & ~hm);
        // a full length id may come with an overlong length
        r.len  = (len == MAX_UID_BYTES && $urandom_range(1)) ?
                 UID_LEN_W'($urandom_range(15, MAX_UID_BYTES)) : len;
        return r;
    endfunction

    task automatic queue_req(t_door_req r);
        door_req_pending_q.push_back(r);
        n_queued++;
    endtask

    // mostly card visits with random content, plus removals, locks, ticks and noise
    task automatic queue_random(int n);
        int start;
        int pick;
        start = n_queued;
        while (n_queued - start < n) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                if ($urandom_range(99) < 10)
                    queue_req(rand_card(REQ_ARRIVE));
                else
                    queue_req(pool_card(REQ_ARRIVE, $urandom_range(POOL_SIZE - 1)));
                if ($urandom_range(1)) queue_req(rand_card(REQ_ENROLL));
                if ($urandom_range(99) < 20) queue_req(rand_card(REQ_LOCK));
                repeat ($urandom_range(3)) queue_req(rand_card(REQ_TICK));
                if ($urandom_range(99) < 85) queue_req(rand_card(REQ_LEAVE));
                repeat ($urandom_range(5)) queue_req(rand_card(REQ_TICK));
            end else if (pick < 60) begin
                if ($urandom_range(99) < 80)
                    queue_req(pool_card(REQ_REMOVE, $urandom_range(POOL_SIZE - 1)));
                else
                    queue_req(rand_card(REQ_REMOVE));
            end else if (pick < 70) begin
                queue_req(rand_card(REQ_LOCK));
            end else if (pick < 85) begin
                repeat ($urandom_range(6, 1)) queue_req(rand_card(REQ_TICK));
            end else begin
                queue_req(rand_card(REQ_W'($urandom_range(7))));
            end
        end
    endtask

    // every queued request taken and every response back
    task automatic wait_idle();
        while (n_taken != n_queued || door_rsp_due_q.size() != 0) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // config writes, only while the block is idle
    // ------------------------------------------------------------------
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_CLOSE_DELAY: cfg_delay      = data;
            CFG_CLOSED_OFS:  cfg_closed_ofs = data[CAL_W-1:0];
            CFG_OPENED_OFS:  cfg_opened_ofs = data[CAL_W-1:0];
            CFG_ZERO_CAL:    cfg_zero_cal   = data[CAL_W-1:0];
            CFG_FULL_CAL:    cfg_full_cal   = data[CAL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(logic [CFG_DATA_W-1:0] dly, logic [CFG_DATA_W-1:0] c_ofs,
                                 logic [CFG_DATA_W-1:0] o_ofs, logic [CFG_DATA_W-1:0] z_cal,
                                 logic [CFG_DATA_W-1:0] f_cal);
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_reg(CFG_CLOSE_DELAY, dly);
        write_reg(CFG_CLOSED_OFS, c_ofs);
        write_reg(CFG_OPENED_OFS, o_ofs);
        write_reg(CFG_ZERO_CAL, z_cal);
        write_reg(CFG_FULL_CAL, f_cal);
        // nothing lives at this index, the write must be dropped
        write_reg(CFG_NO_REG, CFG_DATA_W'($urandom));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // long receiver hold-off so the block backs up into its request side
    task automatic hold_sink(int cycles);
        @(posedge i_clk);
        sink_hold <= 1'b1;
        repeat (cycles) @(posedge i_clk);
        sink_hold <= 1'b0;
    endtask

    task automatic run_phase(logic [CFG_DATA_W-1:0] dly, logic [CFG_DATA_W-1:0] c_ofs,
                             logic [CFG_DATA_W-1:0] o_ofs, logic [CFG_DATA_W-1:0] z_cal,
                             logic [CFG_DATA_W-1:0] f_cal, int src_pct, int snk_pct, int n,
                             bit with_hold);
        apply_setting(dly, c_ofs, o_ofs, z_cal, f_cal);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        if (with_hold) begin
            fork
                hold_sink(600);
            join_none
        end
        queue_random(n / 2);
        // sender pauses until everything has come back
        wait_idle();
        queue_random(n - n / 2);
    endtask

    // ------------------------------------------------------------------
    // request driver: offers queued requests, predicts on acceptance
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                door_rsp_due_q.push_back(predict_door_step(offered_req));
                n_taken++;
            end
            if (!req_if.valid || req_if.ready) begin
                if (door_req_pending_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                    offered_req        = door_req_pending_q.pop_front();
                    req_if.valid     <= 1'b1;
                    req_if.req_type  <= offered_req.kind;
                    req_if.uid_low   <= offered_req.lo;
                    req_if.uid_high  <= offered_req.hi;
                    req_if.uid_bytes <= offered_req.len;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // response monitor: random backpressure, in-order compare
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        n_mismatch++;
        $display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, want);
    endtask

    always @(posedge i_clk) begin
        t_door_rsp want;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (door_rsp_due_q.size() == 0) begin
                    report_mismatch("response with none pending", 64'(rsp_if.status), '0);
                end else begin
                    want = door_rsp_due_q.pop_front();
                    if (rsp_if.status !== want.status)
                        report_mismatch("status", 64'(rsp_if.status), 64'(want.status));
                    if (rsp_if.servo_move !== want.move)
                        report_mismatch("servo_move", 64'(rsp_if.servo_move), 64'(want.move));
                    if (rsp_if.servo_angle !== want.angle)
                        report_mismatch("servo_angle", 64'(rsp_if.servo_angle),
                                        64'(want.angle));
                    if (rsp_if.card_valid !== want.card_ok)
                        report_mismatch("card_valid", 64'(rsp_if.card_valid),
                                        64'(want.card_ok));
                    if (rsp_if.locked_now !== want.locked)
                        report_mismatch("locked_now", 64'(rsp_if.locked_now),
                                        64'(want.locked));
                    if (rsp_if.card_present_now !== want.present)
                        report_mismatch("card_present_now", 64'(rsp_if.card_present_now),
                                        64'(want.present));
                end
            end
            rsp_if.ready <= !sink_hold && ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin
        // known values on every block input from time zero
        req_if.valid     = 1'b0;
        req_if.req_type  = '0;
        req_if.uid_low   = '0;
        req_if.uid_high  = '0;
        req_if.uid_bytes = '0;
        rsp_if.ready     = 1'b0;

        // predictor reset state
        for (int i = 0; i < ACL_SIZE; i++) begin
            acl_lo[i]   = '0;
            acl_hi[i]   = '0;
            acl_len[i]  = '0;
            acl_used[i] = 1'b0;
        end
        acl_lo[0]      = PRESET_ENTRY.lo;
        acl_hi[0]      = PRESET_ENTRY.hi;
        acl_len[0]     = PRESET_ENTRY.len;
        acl_used[0]    = 1'b1;
        cur_lo         = '0;
        cur_hi         = '0;
        cur_len        = '0;
        cur_here       = 1'b0;
        cur_ok         = 1'b0;
        is_locked      = 1'b0;
        close_armed    = 1'b0;
        close_left     = '0;
        cfg_delay      = RST_CLOSE_DELAY;
        cfg_closed_ofs = '0;
        cfg_opened_ofs = '0;
        cfg_zero_cal   = '0;
        cfg_full_cal   = RST_FULL_CAL;

        // id pool: preset card plus at least two ids of every length
        pool_lo[0]  = PRESET_ENTRY.lo;
        pool_hi[0]  = PRESET_ENTRY.hi;
        pool_len[0] = PRESET_ENTRY.len;
        for (int k = 1; k < POOL_SIZE; k++) begin
            pool_lo[k]  = {$urandom, $urandom};
            pool_hi[k]  = UID_HI_W'($urandom);
            pool_len[k] = UID_LEN_W'(k % (MAX_UID_BYTES + 1));
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed requests at reset register values
        queue_req(mk_req(REQ_TICK, '0, '0, '0));                 // tick with nothing pending
        queue_req(mk_req(REQ_LEAVE, '1, '1, '1));                // removal without a card
        queue_req(mk_req(REQ_ARRIVE, {32'hAAAA_5555, PRESET_ENTRY.lo[31:0]}, '1,
                         PRESET_ENTRY.len));                     // garbage past the length
        queue_req(mk_req(REQ_ARRIVE, PRESET_ENTRY.lo, PRESET_ENTRY.hi,
                         PRESET_ENTRY.len));                     // repeated arrival
        queue_req(mk_req(REQ_ENROLL, '0, '0, '0));               // enroll a valid card
        queue_req(mk_req(REQ_ARRIVE, '1, '1, '1));               // overlong length
        queue_req(mk_req(REQ_ENROLL, '1, '1, '1));
        queue_req(mk_req(REQ_ARRIVE, '1, '1, UID_LEN_W'(MAX_UID_BYTES)));
        queue_req(mk_req(REQ_LOCK, '0, '0, '0));                 // lock closes at once
        queue_req(mk_req(REQ_ARRIVE, PRESET_ENTRY.lo, '0, PRESET_ENTRY.len));
        queue_req(mk_req(REQ_LEAVE, '0, '0, '0));                // locked, no countdown
        queue_req(mk_req(REQ_LOCK, '1, '1, '1));                 // unlock
        queue_req(mk_req(REQ_ARRIVE, 64'h0123_4567_89AB_CDEF, 16'h1234, '0)); // zero length
        queue_req(mk_req(REQ_ENROLL, '0, '0, '0));
        queue_req(mk_req(REQ_ARRIVE, 64'hFEDC_BA98_7654_3210, 16'hABCD, '0));
        queue_req(mk_req(REQ_LEAVE, '0, '0, '0));                // starts the long countdown
        queue_req(mk_req(REQ_TICK, '1, '1, '1));
        queue_req(mk_req(REQ_LEAVE, '0, '0, '0));                // no card again
        queue_req(mk_req(REQ_REMOVE, '1, '1, '0));               // frees the zero length id
        queue_req(mk_req(REQ_REMOVE, '0, '0, '0));               // now not found
        queue_req(mk_req(REQ_BAD_6, '1, '1, '1));
        queue_req(mk_req(REQ_BAD_7, '0, '0, '0));
        queue_req(mk_req(REQ_ARRIVE, '1, 16'h00FF, 4'd9));       // nine bytes, high byte ignored
        queue_req(mk_req(REQ_REMOVE, '1, '1, 4'd12));            // ten byte id via overlong length
        queue_req(mk_req(REQ_ENROLL, '1, '1, '1));

        // random phases across register settings and flow control modes
        run_phase(16'd3, 16'd0, 16'd0, 16'd0, 16'd180, 0, 0, 280, 1'b0);
        run_phase(16'd0, 16'd180, 16'd180, 16'd180, 16'd180, 84, 0, 280, 1'b0);
        run_phase(16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 0, 84, 280, 1'b0);
        run_phase(16'hFFFF, 16'd17, 16'd5, 16'd40, 16'd100, 31, 31, 280, 1'b0);
        run_phase(CFG_DATA_W'($urandom_range(4, 1)), CFG_DATA_W'($urandom),
                  CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                  0, 0, 280, 1'b1);

        // drain, then leave room for anything stray
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (n_mismatch == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // run limit
    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
